@@ design/aws_pkg.sv @@
// Shared types and constants for the ascending word sorter.
`default_nettype none
package aws_pkg;

   localparam int WORD_W = 64;

   typedef enum logic [0:0] {
      ST_FILL  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic insert;     // accepted input word goes into the cell row unless the row is full
      logic shift_out;  // head word taken, row moves down by one
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;       // every cell holds a kept word
      logic one_left;   // exactly one word still held
   } dp_sts_type;

endpackage
`default_nettype wire

@@ design/aws_datapath.sv @@
// Insertion cell row, word count and overflow flag of the sorter.
`default_nettype none
module aws_datapath #(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire aws_pkg::dp_cmd_type        cmd,
   input  wire logic [aws_pkg::WORD_W-1:0] in_word,
   output aws_pkg::dp_sts_type             sts,
   output logic [aws_pkg::WORD_W-1:0]      head_word,
   output logic                            ovf
);
   import aws_pkg::*;

   localparam int CntW = $clog2(MAX_ITEMS + 1);

   logic [WORD_W-1:0] word_ff   [MAX_ITEMS];
   logic [WORD_W-1:0] word_in   [MAX_ITEMS];
   logic [WORD_W-1:0] word_prev [MAX_ITEMS];
   logic [WORD_W-1:0] word_next [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] keep;
   logic [MAX_ITEMS-1:0] keep_prev;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            ovf_ff, ovf_in;
   logic            do_insert;

   assign sts.full     = (cnt_ff == CntW'(MAX_ITEMS));
   assign sts.one_left = (cnt_ff == CntW'(1));
   assign do_insert    = cmd.insert && !sts.full;
   assign head_word    = word_ff[0];
   assign ovf          = ovf_ff;

   // a held word stays put when it is no greater than the new one; the kept
   // cells always form a prefix since the row is sorted
   always_comb begin
      for (int k = 0; k < MAX_ITEMS; k++) begin
         keep[k] = (CntW'(k) < cnt_ff) && (word_ff[k] <= in_word);
      end
   end

   assign keep_prev = {keep[MAX_ITEMS-2:0], 1'b1};

   always_comb begin
      word_prev[0]           = in_word;
      word_next[MAX_ITEMS-1] = word_ff[MAX_ITEMS-1];
      for (int k = 1; k < MAX_ITEMS; k++) begin
         word_prev[k]   = word_ff[k-1];
         word_next[k-1] = word_ff[k];
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_ITEMS; k++) begin
         word_in[k] = word_ff[k];
         if (do_insert && !keep[k]) begin
            word_in[k] = keep_prev[k] ? in_word : word_prev[k];
         end else if (cmd.shift_out) begin
            word_in[k] = word_next[k];
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.insert) begin
         if (sts.full) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CntW'(1);
         end
      end else if (cmd.shift_out) begin
         cnt_in = cnt_ff - CntW'(1);
         if (sts.one_left) begin
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_ITEMS; k++) begin
         word_ff[k] <= word_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MAX_ITEMS))
      else $error("word count beyond capacity");

   a_no_empty_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_out |-> cnt_ff != '0)
      else $error("drain with no word held");

   a_drain_order: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_out && !sts.one_left |=> word_ff[0] >= $past(word_ff[0]))
      else $error("drained words out of order");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert && !sts.full |=> cnt_ff == $past(cnt_ff) + CntW'(1))
      else $error("insert did not grow the count");

endmodule
`default_nettype wire

@@ design/aws_controller.sv @@
// Fill/drain state machine and handshake control of the sorter.
`default_nettype none
module aws_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tlast,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire aws_pkg::dp_sts_type sts,
   output aws_pkg::dp_cmd_type      cmd
);
   import aws_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_tready && sts.one_left) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd.insert    = 1'b0;
      cmd.shift_out = 1'b0;
      case (state_ff)
         ST_FILL: begin
            req_tready = 1'b1;
            cmd.insert = req_tvalid;
         end
         ST_DRAIN: begin
            rsp_tvalid    = 1'b1;
            cmd.shift_out = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   a_excl_sides: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and output open together");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("last transaction did not start the drain");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && sts.one_left |=> req_tready)
      else $error("drain did not return to fill");

endmodule
`default_nettype wire

@@ design/ascending_word_sorter.sv @@
// Top level of the ascending word sorter.
// Sorts a run of unsigned 64-bit words into non-decreasing order. Words enter one per
// cycle on the req_ side; each is placed straight into a row of MAX_ITEMS compare-and-
// shift cells, so the row is always sorted. The transaction carrying tlast ends the run:
// the row then drains on the rsp_ side, one word per cycle while rsp_tready is high, from
// the head cell, with tlast on the final word, and the input is held off until the drain
// completes. Words beyond MAX_ITEMS are dropped and every result of that run carries the
// overflow flag in rsp_tuser. Runs are never empty.
`default_nettype none
module ascending_word_sorter #(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [aws_pkg::WORD_W-1:0] req_tdata,   // [63:0] value
   input  wire logic                       req_tlast,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [aws_pkg::WORD_W-1:0]      rsp_tdata,   // [63:0] sorted_value
   output logic                            rsp_tlast,
   output logic                            rsp_tuser    // [0] overflow
);
   import aws_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   aws_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   aws_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_word   (req_tdata),
      .sts       (sts),
      .head_word (rsp_tdata),
      .ovf       (rsp_tuser)
   );

   assign rsp_tlast = sts.one_left;

endmodule
`default_nettype wire

@@ tb/word_sort_checker.sv @@
// Checker for the ascending word sorter: mirrors the sorting row, compares every result.
`timescale 1ns / 100ps
module word_sort_checker #(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] value
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,   // [63:0] sorted_value
   input  wire logic        rsp_tlast,
   input  wire logic        rsp_tuser,   // [0] overflow
   output int               error_count,
   output int               pending,
   output int               results_seen,
   output int               runs_seen,
   output int               overflow_runs
);

   typedef struct {
      logic [63:0] word;
      logic        final_word;
      logic        overflow;
   } sorted_word_type;

   sorted_word_type sorted_due[$];   // results owed by the block, oldest first
   logic [63:0]     kept_words[$];   // words of the current run, kept in ascending order
   bit              words_dropped;

   always @(posedge clock) begin : track
      sorted_word_type due;
      int pos;
      if (reset) begin
         kept_words.delete();
         sorted_due.delete();
         words_dropped = 1'b0;
         error_count = 0;
         pending <= 0;
         results_seen <= 0;
         runs_seen <= 0;
         overflow_runs <= 0;
      end else begin
         // results first: a run's results can only stem from transactions already seen
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (sorted_due.size() == 0) begin
               $error("unexpected result: sorted_value %h", rsp_tdata);
               error_count++;
            end else begin
               due = sorted_due.pop_front();
               if (rsp_tdata !== due.word) begin
                  $error("sorted_value: expected %h, actual %h", due.word, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== due.final_word) begin
                  $error("last_res: expected %b, actual %b", due.final_word, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== due.overflow) begin
                  $error("overflow: expected %b, actual %b", due.overflow, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (kept_words.size() >= MAX_ITEMS) begin
               words_dropped = 1'b1;
            end else begin
               pos = 0;
               // equal words go behind the ones already held
               while (pos < kept_words.size() && kept_words[pos] <= req_tdata) pos++;
               kept_words.insert(pos, req_tdata);
            end
            if (req_tlast) begin
               foreach (kept_words[k]) begin
                  due.word = kept_words[k];
                  due.final_word = (k == kept_words.size() - 1);
                  due.overflow = words_dropped;
                  sorted_due.push_back(due);
               end
               runs_seen <= runs_seen + 1;
               if (words_dropped) overflow_runs <= overflow_runs + 1;
               kept_words.delete();
               words_dropped = 1'b0;
            end
         end
         pending <= sorted_due.size();
      end
   end

endmodule

@@ tb/testbench.sv @@
// Top of the sorter testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module testbench;

   localparam int MAX_ITEMS    = 32;
   localparam int RANDOM_ITEMS = 26;
   localparam int IDLE_LIMIT   = 5000;
   localparam int LONG_HOLD    = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   int error_count, pending, results_seen, runs_seen, overflow_runs;
   int words_sent = 0;
   int burst_left = 0;
   bit pacing_on = 1'b1;
   int idle_cycles = 0;

   ascending_word_sorter #(.MAX_ITEMS(MAX_ITEMS)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   word_sort_checker #(.MAX_ITEMS(MAX_ITEMS)) checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .error_count(error_count), .pending(pending), .results_seen(results_seen),
      .runs_seen(runs_seen), .overflow_runs(overflow_runs)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // no transaction on either side for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: stall pattern switches among always ready, random and mostly stalled modes, plus one long hold
   initial begin : receiver
      int mode;
      int mode_left;
      bit long_hold_done;
      mode = 0;
      mode_left = 0;
      long_hold_done = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_hold_done && rsp_tvalid && results_seen > 40) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 40);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 5))
         0: random_word = 64'($urandom_range(0, 15));          // many duplicates
         1: random_word = ~64'($urandom_range(0, 15));         // near the top
         2: random_word = 64'd1 << $urandom_range(0, 63);
         3: random_word = $urandom_range(0, 1) ? '0 : '1;
         default: random_word = {$urandom, $urandom};
      endcase
   endfunction

   // offer one word and hold it until the block takes it, then maybe idle
   task automatic send_word(input logic [63:0] word, input logic final_word);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tlast <= final_word;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = pacing_on ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_random_run(input int run_len);
      for (int i = 0; i < run_len; i++) send_word(random_word(), i == run_len - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int random_sent;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-word runs at both extremes
      send_word(64'h0, 1'b1);
      send_word('1, 1'b1);
      // equal words
      send_word(64'd5, 1'b0);
      send_word(64'd5, 1'b0);
      send_word(64'd5, 1'b1);
      // strictly descending
      send_word('1, 1'b0);
      send_word(64'h8000_0000_0000_0000, 1'b0);
      send_word(64'd1, 1'b0);
      send_word(64'd0, 1'b1);
      // already ascending
      send_word(64'd0, 1'b0);
      send_word(64'd1, 1'b0);
      send_word(64'd2, 1'b1);
      // mixed, with repeats and both alternating bit patterns
      send_word(64'd7, 1'b0);
      send_word('1, 1'b0);
      send_word(64'd0, 1'b0);
      send_word(64'd7, 1'b0);
      send_word(64'h5555_5555_5555_5555, 1'b0);
      send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      wait_drained();

      // exactly full, then overflowing so that the last two words, the marked one among them, are dropped
      send_random_run(MAX_ITEMS);
      send_random_run(MAX_ITEMS + 2);
      wait_drained();

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         int run_len;
         pacing_on = ($urandom_range(0, 3) != 0);
         run_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 8);
         send_random_run(run_len);
         random_sent += run_len;
      end

      wait_drained();
      repeat (2 * MAX_ITEMS + 10) @(posedge clock);
      $display("Sent %0d words in %0d runs (%0d runs overflowed), checked %0d sorted words.",
               words_sent, runs_seen, overflow_runs, results_seen);
      if (error_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/aws_pkg.sv
design/aws_datapath.sv
design/aws_controller.sv
design/ascending_word_sorter.sv
tb/word_sort_checker.sv
tb/testbench.sv
